// ----- sv/bpp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bpp_pkg
// Types and constants shared by the beacon payload parser modules.
// ---------------------------------------------------------------------------
package bpp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_SHORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_EXT   = 1'b1;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [15:0] OWN_SHORT_RESET = 16'hFFFF;
    localparam logic [63:0] OWN_EXT_RESET   = 64'h0;

    // Output tdata width: 36 payload bits padded to whole bytes
    localparam int unsigned RES_BITS = 36;
    localparam int unsigned RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

    // Payload section being parsed
    typedef enum logic [6:0] {
        SEC_SFSPEC   = 7'b0000001,
        SEC_GTSSPEC  = 7'b0000010,
        SEC_GTSDIR   = 7'b0000100,
        SEC_GTSLIST  = 7'b0001000,
        SEC_PENDSPEC = 7'b0010000,
        SEC_ADDRLIST = 7'b0100000,
        SEC_PAYLOAD  = 7'b1000000
    } t_section;

    // One parse result
    typedef struct packed {
        logic        truncated;
        logic [6:0]  payload_length;
        logic        pending_match;
        logic        gts_direction;
        logic [3:0]  gts_length;
        logic [3:0]  gts_start_slot;
        logic        gts_match;
        logic        gts_allowed;
        logic [15:0] superframe_spec;
    } t_result;

endpackage
`default_nettype wire

// ----- sv/beacon_payload_parser_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// beacon_payload_parser_unit
// Parses a beacon MAC payload byte stream and reports GTS, pending address
// and payload length information once per beacon.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                    contents
//  s_axis    in   tvalid/tready                tdata: data_byte; tlast: last_byte
//  m_axis    out  tvalid/tready                tdata: one result per beacon
//  i_cfg_*   in   i_cfg_we (no wait)           0 own short addr, 1 own ext addr
//
//  One byte per cycle. A byte sits in the input register; when it advances, the
//  parse logic updates state and a last byte's result is loaded into the output
//  register on the same clock edge, which raises m_axis_tvalid.
//  Only a last byte can wait on a full output register; other bytes proceed.
//  Reset (i_rst_n low, synchronous) clears the parse state and loads the own
//  addresses with 0xFFFF and 0.
// ---------------------------------------------------------------------------
module beacon_payload_parser_unit #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 127
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // [7:0] data_byte
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    // [15:0] superframe_spec, [16] gts_allowed, [17] gts_match,
    // [21:18] gts_start_slot, [25:22] gts_length, [26] gts_direction,
    // [27] pending_match, [34:28] payload_length, [35] truncated, [39:36] zero
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [bpp_pkg::RES_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bpp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             w_step;
    logic             w_out_free;
    logic             w_res_valid;
    bpp_pkg::t_result w_res;
    bpp_pkg::t_result w_out_res;

    // Advance a byte unless it is a last byte facing a full output slot
    assign w_step        = r_in_valid && (!r_in_last || w_out_free);
    assign s_axis_tready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    bpp_parse_core #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_step         (w_step),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    bpp_result_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_result (w_res),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_res)
    );

    // Pack result, padded to whole bytes
    assign m_axis_tdata = {{(bpp_pkg::RES_DATA_W - bpp_pkg::RES_BITS){1'b0}}, w_out_res};

endmodule
`default_nettype wire

// ----- sv/bpp_parse_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bpp_parse_core
// Beacon payload parse state and next-state logic, one byte per i_step cycle.
// ---------------------------------------------------------------------------
module bpp_parse_core #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 127
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          i_step,
    input  wire logic [7:0]                    i_byte,
    input  wire logic                          i_last,
    output logic                               o_result_valid,
    output bpp_pkg::t_result                   o_result
);

    localparam logic [6:0] PayCap =
        7'((MAX_PAYLOAD_BYTES < 127) ? MAX_PAYLOAD_BYTES : 127);

    logic [15:0] r_own_short;
    logic [63:0] r_own_ext;

    bpp_pkg::t_section r_section, n_section;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_sf, n_sf;
    logic [2:0]  r_gcount, n_gcount;
    logic [2:0]  r_gidx, n_gidx;
    logic [6:0]  r_mask, n_mask;
    logic [2:0]  r_sleft, n_sleft;
    logic [2:0]  r_eleft, n_eleft;
    logic [63:0] r_shift, n_shift;
    logic        r_gmatch, n_gmatch;
    logic        r_pmatch, n_pmatch;
    logic        r_permit, n_permit;
    logic [3:0]  r_start, n_start;
    logic [3:0]  r_len, n_len;
    logic        r_dir, n_dir;
    logic [6:0]  r_pay, n_pay;

    logic [63:0] w_coll_shift;
    logic [3:0]  w_coll_cnt;
    logic [7:0]  w_mask_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_short <= bpp_pkg::OWN_SHORT_RESET;
            r_own_ext   <= bpp_pkg::OWN_EXT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpp_pkg::CFG_OWN_SHORT: r_own_short <= i_cfg_wdata[15:0];
                bpp_pkg::CFG_OWN_EXT:   r_own_ext   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Shift the byte into the address collector at its byte lane
    assign w_coll_shift = r_shift | ({56'h0, i_byte} << {r_cnt[2:0], 3'b000});
    assign w_coll_cnt   = r_cnt + 4'd1;
    assign w_mask_ext   = {1'b0, r_mask};

    // Next parse state for the byte at hand
    always_comb begin
        n_section = r_section;
        n_cnt     = r_cnt;
        n_sf      = r_sf;
        n_gcount  = r_gcount;
        n_gidx    = r_gidx;
        n_mask    = r_mask;
        n_sleft   = r_sleft;
        n_eleft   = r_eleft;
        n_shift   = r_shift;
        n_gmatch  = r_gmatch;
        n_pmatch  = r_pmatch;
        n_permit  = r_permit;
        n_start   = r_start;
        n_len     = r_len;
        n_dir     = r_dir;
        n_pay     = r_pay;
        case (r_section)
            bpp_pkg::SEC_SFSPEC: begin
                if (r_cnt == 4'd0) begin
                    n_sf  = {8'h00, i_byte};
                    n_cnt = 4'd1;
                end else begin
                    n_sf      = r_sf | {i_byte, 8'h00};
                    n_cnt     = 4'd0;
                    n_section = bpp_pkg::SEC_GTSSPEC;
                end
            end
            bpp_pkg::SEC_GTSSPEC: begin
                n_gcount = i_byte[2:0];
                if (i_byte[7]) begin
                    n_permit = 1'b1;
                end
                n_section = (i_byte[2:0] != 3'd0) ? bpp_pkg::SEC_GTSDIR
                                                  : bpp_pkg::SEC_PENDSPEC;
            end
            bpp_pkg::SEC_GTSDIR: begin
                n_mask    = i_byte[6:0];
                n_gidx    = 3'd0;
                n_cnt     = 4'd0;
                n_shift   = 64'h0;
                n_section = bpp_pkg::SEC_GTSLIST;
            end
            bpp_pkg::SEC_GTSLIST: begin
                if (r_cnt < 4'd2) begin
                    n_shift = w_coll_shift;
                    n_cnt   = w_coll_cnt;
                end else begin
                    // Keep only the first descriptor naming the own address
                    if (!r_gmatch && (r_shift[15:0] == r_own_short)) begin
                        n_gmatch = 1'b1;
                        n_start  = i_byte[3:0];
                        n_len    = i_byte[7:4];
                        n_dir    = w_mask_ext[r_gidx];
                    end
                    n_gidx  = r_gidx + 3'd1;
                    n_cnt   = 4'd0;
                    n_shift = 64'h0;
                    if (n_gidx >= r_gcount) begin
                        n_section = bpp_pkg::SEC_PENDSPEC;
                    end
                end
            end
            bpp_pkg::SEC_PENDSPEC: begin
                n_sleft   = i_byte[2:0];
                n_eleft   = i_byte[6:4];
                n_cnt     = 4'd0;
                n_shift   = 64'h0;
                n_section = ((i_byte[2:0] != 3'd0) || (i_byte[6:4] != 3'd0))
                            ? bpp_pkg::SEC_ADDRLIST : bpp_pkg::SEC_PAYLOAD;
            end
            bpp_pkg::SEC_ADDRLIST: begin
                n_shift = w_coll_shift;
                n_cnt   = w_coll_cnt;
                if (r_sleft != 3'd0) begin
                    if (w_coll_cnt >= 4'd2) begin
                        if (w_coll_shift[15:0] == r_own_short) begin
                            n_pmatch = 1'b1;
                        end
                        n_sleft   = r_sleft - 3'd1;
                        n_cnt     = 4'd0;
                        n_shift   = 64'h0;
                        n_section = ((n_sleft != 3'd0) || (r_eleft != 3'd0))
                                    ? bpp_pkg::SEC_ADDRLIST : bpp_pkg::SEC_PAYLOAD;
                    end
                end else if (w_coll_cnt >= 4'd8) begin
                    if (w_coll_shift == r_own_ext) begin
                        n_pmatch = 1'b1;
                    end
                    if (r_eleft != 3'd0) begin
                        n_eleft = r_eleft - 3'd1;
                    end
                    n_cnt     = 4'd0;
                    n_shift   = 64'h0;
                    n_section = (n_eleft != 3'd0) ? bpp_pkg::SEC_ADDRLIST
                                                  : bpp_pkg::SEC_PAYLOAD;
                end
            end
            bpp_pkg::SEC_PAYLOAD: begin
                // Count payload bytes, saturating at the cap
                if (r_pay < PayCap) begin
                    n_pay = r_pay + 7'd1;
                end
            end
            default: begin
                n_section = bpp_pkg::SEC_SFSPEC;
            end
        endcase
    end

    // Parse state: advance per byte, clear after the last byte of a beacon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_section <= bpp_pkg::SEC_SFSPEC;
            r_cnt     <= 4'd0;
            r_sf      <= 16'h0;
            r_gcount  <= 3'd0;
            r_gidx    <= 3'd0;
            r_mask    <= 7'd0;
            r_sleft   <= 3'd0;
            r_eleft   <= 3'd0;
            r_shift   <= 64'h0;
            r_gmatch  <= 1'b0;
            r_pmatch  <= 1'b0;
            r_permit  <= 1'b0;
            r_start   <= 4'd0;
            r_len     <= 4'd0;
            r_dir     <= 1'b0;
            r_pay     <= 7'd0;
        end else if (i_step) begin
            r_section <= n_section;
            r_cnt     <= n_cnt;
            r_sf      <= n_sf;
            r_gcount  <= n_gcount;
            r_gidx    <= n_gidx;
            r_mask    <= n_mask;
            r_sleft   <= n_sleft;
            r_eleft   <= n_eleft;
            r_shift   <= n_shift;
            r_gmatch  <= n_gmatch;
            r_pmatch  <= n_pmatch;
            r_permit  <= n_permit;
            r_start   <= n_start;
            r_len     <= n_len;
            r_dir     <= n_dir;
            r_pay     <= n_pay;
        end
    end

    // Result of the last byte, taken from the updated state
    always_comb begin
        o_result.superframe_spec = n_sf;
        o_result.gts_allowed     = n_permit;
        o_result.gts_match       = n_gmatch;
        o_result.gts_start_slot  = n_start;
        o_result.gts_length      = n_len;
        o_result.gts_direction   = n_dir;
        o_result.pending_match   = n_pmatch;
        o_result.truncated       = (n_section != bpp_pkg::SEC_PAYLOAD);
        o_result.payload_length  = (n_section != bpp_pkg::SEC_PAYLOAD) ? 7'd0 : n_pay;
    end
    assign o_result_valid = i_step && i_last;

    // Checks
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_section == bpp_pkg::SEC_SFSPEC) && (r_pay == 7'd0))
        else $error("parse state not cleared after last byte");
    a_gts_match_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gmatch && !(i_step && i_last)) |=> r_gmatch)
        else $error("GTS match dropped inside a beacon");
    a_pay_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay <= PayCap)
        else $error("payload count beyond cap");
    a_gts_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_section == bpp_pkg::SEC_GTSLIST) |-> (r_gidx < r_gcount))
        else $error("GTS descriptor index past descriptor count");

endmodule
`default_nettype wire

// ----- sv/bpp_result_reg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// bpp_result_reg
// Output register holding one parse result until the sink takes it.
// ---------------------------------------------------------------------------
module bpp_result_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  bpp_pkg::t_result      i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output bpp_pkg::t_result      o_result
);

    logic             r_valid;
    bpp_pkg::t_result r_result;

    // Slot can take a new result when empty or draining this cycle
    assign o_free = !r_valid || i_ready;

    // Valid flag: set on load, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire
